>>> rtl/crp_pkg.sv
// Shared constants and types for the Catmull-Rom curve point evaluator.
`default_nettype none

package crp_pkg;

    // field and store geometry
    localparam int COORD_WIDTH = 32;
    localparam int MAX_POINTS  = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int TIME_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int NTAPS       = 4;

    // weight arithmetic: numerators are 2*basis*2^48, weights are signed Q.30
    localparam int SQ_W        = 2 * FRAC_W;
    localparam int CUBE_W      = 3 * FRAC_W;
    localparam int NUM_W       = 54;
    localparam int WGT_W       = 32;
    localparam int WGT_SHIFT   = 19;

    // blend arithmetic
    localparam int PROD_W      = WGT_W + COORD_WIDTH;
    localparam int SUM_SHIFT   = 30;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [NUM_W-1:0] NUM_RND = NUM_W'(1) << (WGT_SHIFT - 1);
    // constant term of w1 numerator: 2 * 1.0 * 2^48
    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << 49;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    // [0] = x, [1] = y, [2] = z
    typedef logic [2:0][COORD_WIDTH-1:0]   t_point;
    typedef logic [IDX_W-1:0]              t_idx;
    typedef logic [CNT_W-1:0]              t_cnt;
    typedef logic signed [WGT_W-1:0]       t_wgt;

endpackage

`default_nettype wire

>>> rtl/crp_store.sv
// Control point store: four replicated banks, one read tap per neighbor point.
`default_nettype none

module crp_store import crp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire logic   i_wr,
    input  wire t_idx   i_wr_addr,
    input  wire t_point i_wr_data,
    input  wire t_idx   i_seg,
    input  wire t_cnt   i_n,
    output t_point      o_pt [NTAPS]
);

    t_idx rd_addr [NTAPS];

    // neighbor slots: (seg - 1) mod n, then step forward with wrap at n
    always_comb begin
        if (i_seg == '0) begin
            rd_addr[0] = t_idx'(i_n - t_cnt'(1));
        end else begin
            rd_addr[0] = i_seg - t_idx'(1);
        end
        for (int k = 1; k < NTAPS; k++) begin
            if (({1'b0, rd_addr[k-1]} + t_cnt'(1)) == i_n) begin
                rd_addr[k] = '0;
            end else begin
                rd_addr[k] = rd_addr[k-1] + t_idx'(1);
            end
        end
    end

    // every bank takes every write, each bank serves one tap
    for (genvar b = 0; b < NTAPS; b++) begin : g_bank
        t_point r_mem [MAX_POINTS];
        t_point r_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_wr) begin
                    r_mem[i_wr_addr] <= i_wr_data;
                end
                r_rd <= r_mem[rd_addr[b]];
            end
        end

        assign o_pt[b] = r_rd;
    end

endmodule

`default_nettype wire

>>> rtl/crp_weights.sv
// Catmull-Rom basis weights in signed Q.30 from the local parameter, three stages.
`default_nettype none

module crp_weights import crp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [FRAC_W-1:0] i_u,
    output t_wgt                   o_w [NTAPS]
);

    logic [FRAC_W-1:0] r_u;
    logic [SQ_W-1:0]   r_sq;
    logic [CUBE_W-1:0] r_cube;
    logic [NUM_W-1:0]  r_part [NTAPS];
    t_wgt              r_w    [NTAPS];

    logic [NUM_W-1:0]  sq_s;
    logic [NUM_W-1:0]  u_s;
    logic [NUM_W-1:0]  cu;
    logic [NUM_W-1:0]  n_part [NTAPS];
    logic [NUM_W-1:0]  num    [NTAPS];

    // u^2 * 2^16 and u * 2^32 terms plus the rounding half
    always_comb begin
        sq_s      = NUM_W'(r_sq) << FRAC_W;
        u_s       = NUM_W'(r_u) << SQ_W;
        n_part[0] = (sq_s << 1) - u_s + NUM_RND;
        n_part[1] = NUM_ONE - (sq_s << 2) - sq_s + NUM_RND;
        n_part[2] = (sq_s << 2) + u_s + NUM_RND;
        n_part[3] = NUM_RND - sq_s;
    end

    // add the cubic term; modular 54-bit math, true values stay in range
    always_comb begin
        cu     = NUM_W'(r_cube);
        num[0] = r_part[0] - cu;
        num[1] = r_part[1] + (cu << 1) + cu;
        num[2] = r_part[2] - (cu << 1) - cu;
        num[3] = r_part[3] + cu;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: square
            r_u  <= i_u;
            r_sq <= i_u * i_u;
            // stage 2: cube and lower-order terms
            r_cube <= r_sq * r_u;
            for (int k = 0; k < NTAPS; k++) begin
                r_part[k] <= n_part[k];
            end
            // stage 3: floor shift to Q.30
            for (int k = 0; k < NTAPS; k++) begin
                r_w[k] <= t_wgt'(num[k][WGT_SHIFT +: WGT_W]);
            end
        end
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

>>> rtl/crp_blend.sv
// Weighted sum of four points per coordinate, rounding and saturation.
`default_nettype none

module crp_blend import crp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_point i_pt [NTAPS],
    input  wire t_wgt   i_w  [NTAPS],
    output t_point      o_pos
);

    localparam int SUM_W = PROD_W + 2;
    localparam int RES_W = SUM_W - SUM_SHIFT;
    localparam logic [SUM_W-1:0] SUM_RND = SUM_W'(1) << (SUM_SHIFT - 1);

    t_point                   r_pt_d1 [NTAPS];
    t_point                   r_pt_d2 [NTAPS];
    logic signed [PROD_W-1:0] r_prod  [3][NTAPS];
    logic signed [PROD_W:0]   r_pair  [3][2];
    t_point                   r_pos;

    logic [SUM_W-1:0] total [3];
    logic [RES_W-1:0] res   [3];
    t_point           n_pos;

    // final add, round to coordinate LSB, clamp to the signed range
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            total[c] = {r_pair[c][0][PROD_W], r_pair[c][0]}
                     + {r_pair[c][1][PROD_W], r_pair[c][1]} + SUM_RND;
            res[c]   = total[c][SUM_W-1 -: RES_W];
            if ((~|res[c][RES_W-1:COORD_WIDTH-1]) || (&res[c][RES_W-1:COORD_WIDTH-1])) begin
                n_pos[c] = res[c][COORD_WIDTH-1:0];
            end else if (res[c][RES_W-1]) begin
                n_pos[c] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                n_pos[c] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // points wait two stages for the weights
            for (int k = 0; k < NTAPS; k++) begin
                r_pt_d1[k] <= i_pt[k];
                r_pt_d2[k] <= r_pt_d1[k];
            end
            // one 32x32 product per tap and coordinate
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < NTAPS; k++) begin
                    r_prod[c][k] <= i_w[k] * t_coord'(r_pt_d2[k][c]);
                end
            end
            // pairwise sums
            for (int c = 0; c < 3; c++) begin
                r_pair[c][0] <= {r_prod[c][0][PROD_W-1], r_prod[c][0]}
                              + {r_prod[c][1][PROD_W-1], r_prod[c][1]};
                r_pair[c][1] <= {r_prod[c][2][PROD_W-1], r_prod[c][2]}
                              + {r_prod[c][3][PROD_W-1], r_prod[c][3]};
            end
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

>>> rtl/catmull_rom_curve_point.sv
// Top level: closed-loop uniform Catmull-Rom curve point evaluator.
//
//  channel   handshake                   word
//  -------   -------------------------   ---------------------------------------------
//  input     i_valid / o_ready           i_func, i_point_index, i_coord_*, i_curve_time
//  result    o_valid / i_ready           o_pos_x, o_pos_y, o_pos_z
//  config    i_cfg_valid / o_cfg_ready   i_cfg_point_count
//
// One word accepted per cycle while o_ready is high. Loads give no result and write the
// store in stage 2, the same stage that reads it, so loads and evaluates see the store in
// arrival order. One shared enable moves all stages; it drops only while a result waits
// on the output. Synchronous active-low reset clears valids and sets the point count to
// 4; store contents are undefined until written.
`default_nettype none

module catmull_rom_curve_point import crp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CNT_W-1:0]       i_cfg_point_count,
    // input words
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_func,
    input  wire logic [IDX_W-1:0]       i_point_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  wire logic [TIME_W-1:0]      i_curve_time,
    // results
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z
);

    logic en;
    t_cnt n_eff;
    logic [FRAC_W+CNT_W-1:0] seg_prod;
    logic store_wr;

    t_cnt r_point_count;

    logic              r_s1_valid;
    t_func             r_s1_func;
    t_idx              r_s1_idx;
    t_point            r_s1_pt;
    logic [FRAC_W-1:0] r_s1_frac;
    t_cnt              r_s1_n;

    logic              r_s2_valid;
    t_func             r_s2_func;
    t_idx              r_s2_idx;
    t_point            r_s2_pt;
    t_idx              r_s2_seg;
    logic [FRAC_W-1:0] r_s2_u;
    t_cnt              r_s2_n;

    // valids of evaluate words in stages 3..7, then the output register
    logic [4:0]        r_vpipe;
    logic              r_out_valid;

    t_point store_pt [NTAPS];
    t_wgt   wgt      [NTAPS];
    t_point pos;

    assign en          = !r_out_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    // point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= t_cnt'(4);
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_point_count;
        end
    end

    // zero acts as one, counts above the store depth act as the depth
    always_comb begin
        if (r_point_count == '0) begin
            n_eff = t_cnt'(1);
        end else if (r_point_count > CNT_MAX) begin
            n_eff = CNT_MAX;
        end else begin
            n_eff = r_point_count;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_vpipe     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_vpipe     <= {r_vpipe[3:0], r_s2_valid && (r_s2_func == FUNC_EVAL)};
            r_out_valid <= r_vpipe[4];
        end
    end

    // fraction times count: segment in the integer bits, local t in the fraction
    assign seg_prod = r_s1_frac * r_s1_n;

    // stage 1 and 2 payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_func <= t_func'(i_func);
            r_s1_idx  <= i_point_index;
            r_s1_pt   <= {i_coord_z, i_coord_y, i_coord_x};
            r_s1_frac <= i_curve_time[FRAC_W-1:0];
            r_s1_n    <= n_eff;

            r_s2_func <= r_s1_func;
            r_s2_idx  <= r_s1_idx;
            r_s2_pt   <= r_s1_pt;
            r_s2_seg  <= seg_prod[FRAC_W +: IDX_W];
            r_s2_u    <= seg_prod[FRAC_W-1:0];
            r_s2_n    <= r_s1_n;
        end
    end

    // loads beyond the store depth are dropped
    assign store_wr = en && r_s2_valid && (r_s2_func == FUNC_LOAD)
                   && ({1'b0, r_s2_idx} < CNT_MAX);

    crp_store u_store (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_wr      (store_wr),
        .i_wr_addr (r_s2_idx),
        .i_wr_data (r_s2_pt),
        .i_seg     (r_s2_seg),
        .i_n       (r_s2_n),
        .o_pt      (store_pt)
    );

    crp_weights u_weights (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (r_s2_u),
        .o_w   (wgt)
    );

    crp_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en),
        .i_pt  (store_pt),
        .i_w   (wgt),
        .o_pos (pos)
    );

    assign o_valid = r_out_valid;
    assign o_pos_x = t_coord'(pos[0]);
    assign o_pos_y = t_coord'(pos[1]);
    assign o_pos_z = t_coord'(pos[2]);

`ifndef SYNTHESIS
    a_seg_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && (r_s2_func == FUNC_EVAL)) |-> (t_cnt'(r_s2_seg) < r_s2_n))
        else $error("segment index not below point count");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((r_s1_n != '0) && (r_s1_n <= CNT_MAX)))
        else $error("effective point count out of range");

    a_only_eval_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s2_valid) |=> (r_vpipe[0] == $past(r_s2_func == FUNC_EVAL)))
        else $error("load word entered result pipeline or evaluate word lost");

    a_stall_holds_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable({r_s1_valid, r_s2_valid, r_vpipe, r_out_valid}))
        else $error("pipeline valids moved during stall");
`endif

endmodule

`default_nettype wire
